### src/tccw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared sizes, codes and types of the text console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int ACT_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 7;
    localparam int COLOR_W = 8;
    localparam int RADDR_W = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;
    localparam int ADDR_W  = $clog2(CELL_COUNT);

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COL_W-1:0]   t_col;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [CELL_W-1:0]  t_cell;

    localparam t_color COLOR_RESET  = 8'h0F;
    localparam t_char  CH_NEWLINE   = 8'h0A;
    localparam t_char  CH_BACKSPACE = 8'h08;
    localparam t_char  CH_SPACE     = 8'h20;
    localparam t_col   COL_LAST     = COL_W'(COLUMNS - 1);
    localparam t_addr  ADDR_LAST    = ADDR_W'(CELL_COUNT - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT       = 4'd0,
        ACT_LEFT      = 4'd1,
        ACT_RIGHT     = 4'd2,
        ACT_CLR_EOL   = 4'd3,
        ACT_CLR_SCR   = 4'd4,
        ACT_SET_COL   = 4'd5,
        ACT_SET_ROW   = 4'd6,
        ACT_SET_COLOR = 4'd7,
        ACT_RST_COLOR = 4'd8,
        ACT_READ      = 4'd9
    } t_action;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_cell wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

    typedef struct packed {
        t_col   col;
        t_row   row;
        t_color color;
        t_cell  word;
    } t_result;

    function automatic t_addr cell_addr(input t_row row, input t_col col);
        cell_addr = t_addr'(row) * t_addr'(COLUMNS) + t_addr'(col);
    endfunction

endpackage
`default_nettype wire

### src/text_console_cursor_writer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_writer_top
// Text console engine: screen cell RAM, cursor, colors and a result register.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  in       | i_in_valid / o_in_stall  | action, char_code, position, color, addr
//  out      | o_out_valid / i_out_stall| cursor_column/line, active_color, cell
//  cfg      | i_cfg_valid / o_cfg_ready| default color byte
//
//  put char, cursor moves, set and color actions pass through DONE only; read cell
//  also passes through READ for the registered RAM read, skipped when the address is
//  off screen; clear to end of line and clear screen (also on scroll past the
//  bottom) sweep through SWEEP, one cell per cycle.
//  after reset the RAM is filled with CELL_COUNT (2000) blank cells
//  with o_in_stall high; cfg beats are taken throughout.
//  a result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [tccw_pkg::ACT_W-1:0]       i_action,
    input  wire logic [tccw_pkg::CHAR_W-1:0]      i_char_code,
    input  wire logic [tccw_pkg::POS_W-1:0]       i_position,
    input  wire logic [tccw_pkg::COLOR_W-1:0]     i_color_value,
    input  wire logic [tccw_pkg::RADDR_W-1:0]     i_cell_address,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [tccw_pkg::COL_W-1:0]            o_cursor_column,
    output logic [tccw_pkg::ROW_W-1:0]            o_cursor_line,
    output logic [tccw_pkg::COLOR_W-1:0]          o_active_color,
    output logic [tccw_pkg::CELL_W-1:0]           o_cell_word,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tccw_pkg::COLOR_W-1:0]     i_cfg_data
);

    tccw_pkg::t_mem_req mem_req;
    tccw_pkg::t_result  result;
    tccw_pkg::t_cell    rd_data;
    tccw_pkg::t_result  r_out;
    logic               r_out_valid;
    logic               out_free;
    logic               push;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    tccw_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_char_code    (i_char_code),
        .i_position     (i_position),
        .i_color_value  (i_color_value),
        .i_cell_address (i_cell_address),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_out_free     (out_free),
        .o_push         (push),
        .o_result       (result),
        .o_mem          (mem_req),
        .i_rd_data      (rd_data)
    );

    tccw_ram #(
        .DEPTH (tccw_pkg::CELL_COUNT),
        .WIDTH (tccw_pkg::CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_column = r_out.col;
    assign o_cursor_line   = r_out.row;
    assign o_active_color  = r_out.color;
    assign o_cell_word     = r_out.word;

endmodule
`default_nettype wire

### src/tccw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### src/tccw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_ctrl
// Action sequencer: cursor and color registers, cell writes and fill sweeps.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [tccw_pkg::ACT_W-1:0]       i_action,
    input  wire logic [tccw_pkg::CHAR_W-1:0]      i_char_code,
    input  wire logic [tccw_pkg::POS_W-1:0]       i_position,
    input  wire logic [tccw_pkg::COLOR_W-1:0]     i_color_value,
    input  wire logic [tccw_pkg::RADDR_W-1:0]     i_cell_address,
    input  wire logic                             i_cfg_we,
    input  wire logic [tccw_pkg::COLOR_W-1:0]     i_cfg_data,
    input  wire logic                             i_out_free,
    output logic                                  o_push,
    output tccw_pkg::t_result                     o_result,
    output tccw_pkg::t_mem_req                    o_mem,
    input  wire tccw_pkg::t_cell                  i_rd_data
);

    tccw_pkg::t_state r_state, n_state;
    tccw_pkg::t_col   r_col, n_col;
    tccw_pkg::t_row   r_row, n_row;
    tccw_pkg::t_color r_color, n_color;
    tccw_pkg::t_color r_default, n_default;
    tccw_pkg::t_addr  r_addr, n_addr;
    tccw_pkg::t_addr  r_last, n_last;
    tccw_pkg::t_cell  r_fill, n_fill;
    tccw_pkg::t_cell  r_cell, n_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tccw_pkg::ST_INIT;
            r_col     <= '0;
            r_row     <= '0;
            r_color   <= tccw_pkg::COLOR_RESET;
            r_default <= tccw_pkg::COLOR_RESET;
            r_addr    <= '0;
            r_last    <= tccw_pkg::ADDR_LAST;
            r_fill    <= {tccw_pkg::COLOR_RESET, tccw_pkg::CH_SPACE};
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_color   <= n_color;
            r_default <= n_default;
            r_addr    <= n_addr;
            r_last    <= n_last;
            r_fill    <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_comb begin
        tccw_pkg::t_col col_v;
        tccw_pkg::t_row row_v;
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_color   = r_color;
        n_default = r_default;
        n_addr    = r_addr;
        n_last    = r_last;
        n_fill    = r_fill;
        n_cell    = r_cell;
        o_mem     = '0;
        o_push    = 1'b0;
        col_v     = r_col;
        row_v     = r_row;

        case (r_state)
            tccw_pkg::ST_INIT, tccw_pkg::ST_SWEEP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_addr;
                o_mem.wdata = r_fill;
                if (r_addr == r_last) begin
                    n_state = (r_state == tccw_pkg::ST_INIT) ? tccw_pkg::ST_IDLE
                                                             : tccw_pkg::ST_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            tccw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_cell  = '0;
                    n_state = tccw_pkg::ST_DONE;
                    case (tccw_pkg::t_action'(i_action))
                        tccw_pkg::ACT_PUT: begin
                            if (i_char_code == tccw_pkg::CH_NEWLINE) begin
                                col_v = '0;
                                row_v = r_row + 1'b1;
                            end else if (i_char_code == tccw_pkg::CH_BACKSPACE) begin
                                if (r_col != '0) begin
                                    col_v       = r_col - 1'b1;
                                    o_mem.we    = 1'b1;
                                    o_mem.waddr = tccw_pkg::cell_addr(r_row, col_v);
                                    o_mem.wdata = {r_color, tccw_pkg::CH_SPACE};
                                end
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = tccw_pkg::cell_addr(r_row, r_col);
                                o_mem.wdata = {r_color, i_char_code};
                                col_v       = r_col + 1'b1;
                            end
                            if (col_v > tccw_pkg::COL_LAST) begin
                                col_v = '0;
                                row_v = row_v + 1'b1;
                            end
                            if (32'(row_v) >= tccw_pkg::ROWS) begin
                                // scrolled past the bottom: wipe and home
                                n_col   = '0;
                                n_row   = '0;
                                n_color = r_default;
                                n_addr  = '0;
                                n_last  = tccw_pkg::ADDR_LAST;
                                n_fill  = {r_default, tccw_pkg::CH_SPACE};
                                n_state = tccw_pkg::ST_SWEEP;
                            end else begin
                                n_col = col_v;
                                n_row = row_v;
                            end
                        end
                        tccw_pkg::ACT_LEFT: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end
                        end
                        tccw_pkg::ACT_RIGHT: begin
                            if (r_col < tccw_pkg::COL_LAST) begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        tccw_pkg::ACT_CLR_EOL: begin
                            n_addr  = tccw_pkg::cell_addr(r_row, r_col);
                            n_last  = tccw_pkg::cell_addr(r_row, tccw_pkg::COL_LAST);
                            n_fill  = {r_color, tccw_pkg::CH_SPACE};
                            n_state = tccw_pkg::ST_SWEEP;
                        end
                        tccw_pkg::ACT_CLR_SCR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_color = r_default;
                            n_addr  = '0;
                            n_last  = tccw_pkg::ADDR_LAST;
                            n_fill  = {r_default, tccw_pkg::CH_SPACE};
                            n_state = tccw_pkg::ST_SWEEP;
                        end
                        tccw_pkg::ACT_SET_COL: begin
                            if (32'(i_position) < tccw_pkg::COLUMNS) begin
                                n_col = tccw_pkg::t_col'(i_position);
                            end
                        end
                        tccw_pkg::ACT_SET_ROW: begin
                            if (32'(i_position) < tccw_pkg::ROWS) begin
                                n_row = tccw_pkg::t_row'(i_position);
                            end
                        end
                        tccw_pkg::ACT_SET_COLOR: begin
                            n_color = i_color_value;
                        end
                        tccw_pkg::ACT_RST_COLOR: begin
                            n_color = r_default;
                        end
                        tccw_pkg::ACT_READ: begin
                            if (32'(i_cell_address) < tccw_pkg::CELL_COUNT) begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = tccw_pkg::t_addr'(i_cell_address);
                                n_state     = tccw_pkg::ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tccw_pkg::ST_READ: begin
                n_cell  = i_rd_data;
                n_state = tccw_pkg::ST_DONE;
            end
            tccw_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = tccw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tccw_pkg::ST_IDLE;
            end
        endcase

        // default color write also reloads the current color
        if (i_cfg_we) begin
            n_default = i_cfg_data;
            n_color   = i_cfg_data;
        end
    end

    assign o_in_stall      = (r_state != tccw_pkg::ST_IDLE);
    assign o_result.col    = r_col;
    assign o_result.row    = r_row;
    assign o_result.color  = r_color;
    assign o_result.word   = r_cell;

`ifndef ASSERT_OFF
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < tccw_pkg::COLUMNS)
        else $error("cursor column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < tccw_pkg::ROWS)
        else $error("cursor row out of range");
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (32'(o_mem.waddr) < tccw_pkg::CELL_COUNT))
        else $error("screen write beyond last cell");
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tccw_pkg::ST_READ) |=> (r_state == tccw_pkg::ST_DONE))
        else $error("read data not captured");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tccw_pkg::ST_IDLE && i_in_valid) |=> o_in_stall)
        else $error("second beat taken while first in flight");
`endif

endmodule
`default_nettype wire

### bench/tb_text_console_cursor_writer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_writer_top
// Self-checking bench for the text console. A short script of edge cases runs
// first, then weighted random console traffic under several default colors.
// Every result beat is scored against an in-bench copy of the screen, the
// cursor and the colors, or a hand-written result where a script row has one.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_writer_top;
    import tccw_pkg::*;

    localparam int CYCLE_LIMIT    = 9_000_000;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 200;
    localparam int PRESSURE_PHASE = 1;
    localparam int QUIET_PHASE    = 3;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 16;
    localparam int SCRIPT_LEN     = 25;

    localparam logic [ACT_W-1:0]   ACT_SPARE_FIRST = 4'd10;
    localparam logic [ACT_W-1:0]   ACT_SPARE_LAST  = 4'd15;
    localparam logic [RADDR_W-1:0] RADDR_TOP       = '1;
    localparam t_char              CH_LETTER_A     = 8'h41;
    localparam t_cell              BLANK_RESET     = {COLOR_RESET, CH_SPACE};
    localparam t_cell              NO_CELL         = 16'h0000;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        t_char              ch;
        logic [POS_W-1:0]   pos;
        t_color             color;
        logic [RADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        t_cmd    cmd;
        logic    has_want;
        t_result want;
    } t_script_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [ACT_W-1:0]     i_action;
    logic [CHAR_W-1:0]    i_char_code;
    logic [POS_W-1:0]     i_position;
    logic [COLOR_W-1:0]   i_color_value;
    logic [RADDR_W-1:0]   i_cell_address;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [COL_W-1:0]     o_cursor_column;
    logic [ROW_W-1:0]     o_cursor_line;
    logic [COLOR_W-1:0]   o_active_color;
    logic [CELL_W-1:0]    o_cell_word;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [COLOR_W-1:0]   i_cfg_data;

    // console image kept in step with every accepted beat
    t_cell   screen_image [CELL_COUNT];
    t_col    cur_col;
    t_row    cur_row;
    t_color  cur_color;
    t_color  dflt_color;
    t_result status_due [$];

    int fail_count   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int reads_seen   = 0;
    int wipes_seen   = 0;
    int color_loads  = 0;
    int phase_no     = -1;
    bit quiet        = 1'b0;

    // edge cases; rows with has_want set carry a hand-written result
    t_script_row edge_script [SCRIPT_LEN] = '{
        '{'{ACT_READ, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd0, 5'd0, COLOR_RESET, BLANK_RESET}},
        '{'{ACT_READ, 8'hFF, 7'h7F, 8'hFF, ADDR_LAST}, 1'b1,
          '{7'd0, 5'd0, COLOR_RESET, BLANK_RESET}},
        '{'{ACT_READ, 8'h00, 7'd0, 8'h00, RADDR_TOP}, 1'b1,
          '{7'd0, 5'd0, COLOR_RESET, NO_CELL}},
        '{'{ACT_LEFT, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd0, 5'd0, COLOR_RESET, NO_CELL}},
        '{'{ACT_PUT, CH_BACKSPACE, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd0, 5'd0, COLOR_RESET, NO_CELL}},
        '{'{ACT_SET_COLOR, 8'h00, 7'd0, 8'hA5, 11'd0}, 1'b1,
          '{7'd0, 5'd0, 8'hA5, NO_CELL}},
        '{'{ACT_PUT, 8'hFF, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd1, 5'd0, 8'hA5, NO_CELL}},
        '{'{ACT_READ, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd1, 5'd0, 8'hA5, 16'hA5FF}},
        '{'{ACT_PUT, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b0, '0},
        '{'{ACT_PUT, CH_BACKSPACE, 7'd0, 8'h00, 11'd0}, 1'b0, '0},
        '{'{ACT_READ, 8'h00, 7'd0, 8'h00, 11'd1}, 1'b0, '0},
        '{'{ACT_SET_COL, 8'h00, COL_LAST, 8'h00, 11'd0}, 1'b1,
          '{COL_LAST, 5'd0, 8'hA5, NO_CELL}},
        '{'{ACT_RIGHT, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{COL_LAST, 5'd0, 8'hA5, NO_CELL}},
        '{'{ACT_SET_COL, 8'h00, 7'(COLUMNS), 8'h00, 11'd0}, 1'b1,
          '{COL_LAST, 5'd0, 8'hA5, NO_CELL}},
        '{'{ACT_PUT, CH_LETTER_A, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd0, 5'd1, 8'hA5, NO_CELL}},
        '{'{ACT_SET_ROW, 8'h00, 7'h7F, 8'h00, 11'd0}, 1'b1,
          '{7'd0, 5'd1, 8'hA5, NO_CELL}},
        '{'{ACT_SET_ROW, 8'h00, 7'(ROWS - 1), 8'h00, 11'd0}, 1'b0, '0},
        '{'{ACT_SET_COL, 8'h00, 7'd40, 8'h00, 11'd0}, 1'b0, '0},
        '{'{ACT_CLR_EOL, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b0, '0},
        '{'{ACT_READ, 8'h00, 7'd0, 8'h00, ADDR_LAST}, 1'b0, '0},
        '{'{ACT_PUT, CH_NEWLINE, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd0, 5'd0, COLOR_RESET, NO_CELL}},
        '{'{ACT_SET_COLOR, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b0, '0},
        '{'{ACT_RST_COLOR, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd0, 5'd0, COLOR_RESET, NO_CELL}},
        '{'{ACT_SPARE_LAST, 8'hFF, 7'h7F, 8'hFF, RADDR_TOP}, 1'b0, '0},
        '{'{ACT_CLR_SCR, 8'h00, 7'd0, 8'h00, 11'd0}, 1'b1,
          '{7'd0, 5'd0, COLOR_RESET, NO_CELL}}
    };

    text_console_cursor_writer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_char_code    (i_char_code),
        .i_position     (i_position),
        .i_color_value  (i_color_value),
        .i_cell_address (i_cell_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_column(o_cursor_column),
        .o_cursor_line  (o_cursor_line),
        .o_active_color (o_active_color),
        .o_cell_word    (o_cell_word),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int cell_at(input t_row r, input t_col c);
        return int'(r) * COLUMNS + int'(c);
    endfunction

    function automatic void blank_screen();
        foreach (screen_image[i]) screen_image[i] = {dflt_color, CH_SPACE};
        cur_col    = '0;
        cur_row    = '0;
        cur_color  = dflt_color;
        wipes_seen++;
    endfunction

    // moves the console image through one action, returns the status beat
    function automatic t_result apply_console_action(input t_cmd cmd);
        t_result r;
        r.word = '0;
        case (cmd.action)
            ACT_PUT: begin
                if (cmd.ch == CH_NEWLINE) begin
                    cur_col = '0;
                    cur_row++;
                end else if (cmd.ch == CH_BACKSPACE) begin
                    if (cur_col != 0) begin
                        cur_col--;
                        screen_image[cell_at(cur_row, cur_col)] = {cur_color, CH_SPACE};
                    end
                end else begin
                    screen_image[cell_at(cur_row, cur_col)] = {cur_color, cmd.ch};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = '0;
                    cur_row++;
                end
                // running off the bottom wipes the screen
                if (cur_row >= ROWS) blank_screen();
            end
            ACT_LEFT:      if (cur_col != 0) cur_col--;
            ACT_RIGHT:     if (cur_col < COL_LAST) cur_col++;
            ACT_CLR_EOL: begin
                for (int c = int'(cur_col); c < COLUMNS; c++)
                    screen_image[cell_at(cur_row, t_col'(c))] = {cur_color, CH_SPACE};
            end
            ACT_CLR_SCR:   blank_screen();
            ACT_SET_COL:   if (cmd.pos < COLUMNS) cur_col = t_col'(cmd.pos);
            ACT_SET_ROW:   if (cmd.pos < ROWS) cur_row = t_row'(cmd.pos);
            ACT_SET_COLOR: cur_color = cmd.color;
            ACT_RST_COLOR: cur_color = dflt_color;
            ACT_READ: begin
                reads_seen++;
                if (cmd.addr < CELL_COUNT) r.word = screen_image[cmd.addr];
            end
            default: ;
        endcase
        r.col   = cur_col;
        r.row   = cur_row;
        r.color = cur_color;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        int   sel;
        c.action = ACT_W'($urandom);
        c.ch     = t_char'($urandom);
        c.pos    = POS_W'($urandom);
        c.color  = t_color'($urandom);
        c.addr   = RADDR_W'($urandom);
        pick     = $urandom_range(0, 99);
        sel      = $urandom_range(0, 9);
        if (pick < 45) begin
            c.action = ACT_PUT;
            if (sel == 0) c.ch = CH_NEWLINE;
            else if (sel == 1) c.ch = CH_BACKSPACE;
            else if (sel < 9) c.ch = t_char'($urandom_range(32, 126));
        end else if (pick < 51) begin
            c.action = ACT_LEFT;
        end else if (pick < 57) begin
            c.action = ACT_RIGHT;
        end else if (pick < 62) begin
            c.action = ACT_CLR_EOL;
        end else if (pick < 63) begin
            c.action = ACT_CLR_SCR;
        end else if (pick < 70) begin
            c.action = ACT_SET_COL;
            c.pos = (sel < 2) ? POS_W'($urandom_range(COLUMNS, 127))
                              : POS_W'($urandom_range(0, COLUMNS - 1));
        end else if (pick < 77) begin
            c.action = ACT_SET_ROW;
            if (sel < 2) c.pos = POS_W'($urandom_range(ROWS, 127));
            else if (sel < 4) c.pos = POS_W'(ROWS - 1);
            else c.pos = POS_W'($urandom_range(0, ROWS - 1));
        end else if (pick < 83) begin
            c.action = ACT_SET_COLOR;
        end else if (pick < 86) begin
            c.action = ACT_RST_COLOR;
        end else if (pick < 98) begin
            c.action = ACT_READ;
            // half the reads land on the cursor row, where the writes go
            if (sel == 0) c.addr = RADDR_W'($urandom_range(CELL_COUNT, 2047));
            else if (sel < 6)
                c.addr = RADDR_W'(cell_at(cur_row, t_col'($urandom_range(0, COLUMNS - 1))));
            else c.addr = RADDR_W'($urandom_range(0, CELL_COUNT - 1));
        end else begin
            c.action = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end
        return c;
    endfunction

    // called and returns at a falling edge
    task automatic offer_cmd(input t_cmd cmd, input logic has_want, input t_result want);
        int      gap;
        t_result predicted;
        gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= cmd.action;
        i_char_code    <= cmd.ch;
        i_position     <= cmd.pos;
        i_color_value  <= cmd.color;
        i_cell_address <= cmd.addr;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_console_action(cmd);
        status_due.push_back(has_want ? want : predicted);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_default_color(input t_color val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        dflt_color = val;
        cur_color  = val;
        color_loads++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : result_sink
        int stall_left;
        bit long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        i_out_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_no == PRESSURE_PHASE && !long_hold_done) begin
                // hold results back so the block fills and stalls its input
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD - 1;
                i_out_stall   <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (quiet || $urandom_range(0, 99) < 70) begin
                i_out_stall <= 1'b0;
            end else begin
                stall_left   = gap_len() - 1;
                i_out_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (status_due.size() == 0) begin
                $error("result beat with nothing outstanding: col %0d line %0d",
                       o_cursor_column, o_cursor_line);
                fail_count++;
            end else begin
                want = status_due.pop_front();
                if (o_cursor_column !== want.col) begin
                    $error("cursor_column: expected %0d, actual %0d",
                           want.col, o_cursor_column);
                    fail_count++;
                end
                if (o_cursor_line !== want.row) begin
                    $error("cursor_line: expected %0d, actual %0d", want.row, o_cursor_line);
                    fail_count++;
                end
                if (o_active_color !== want.color) begin
                    $error("active_color: expected %02h, actual %02h",
                           want.color, o_active_color);
                    fail_count++;
                end
                if (o_cell_word !== want.word) begin
                    $error("cell_word: expected %04h, actual %04h", want.word, o_cell_word);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, status_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_color setting;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = '0;
        i_char_code    = '0;
        i_position     = '0;
        i_color_value  = '0;
        i_cell_address = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        dflt_color     = COLOR_RESET;
        blank_screen();
        wipes_seen     = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (edge_script[k])
            offer_cmd(edge_script[k].cmd, edge_script[k].has_want, edge_script[k].want);

        for (int p = 0; p < PHASES; p++) begin
            i_in_valid <= 1'b0;
            while (status_due.size() != 0) @(negedge i_clk);
            if (p == 0) setting = 8'h00;
            else if (p == 1) setting = 8'hFF;
            else setting = t_color'($urandom);
            load_default_color(setting);
            quiet    = (p == QUIET_PHASE);
            phase_no = p;
            repeat (PHASE_ITEMS) offer_cmd(random_cmd(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d console actions and %0d result beats, %0d of them cell reads",
                 items_sent, results_seen, reads_seen);
        $display("screen wipes %0d, default color loads %0d, one %0d-cycle output hold",
                 wipes_seen, color_loads, LONG_HOLD);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
